FILE: rtl/dwcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA window composition check - shared package
// Widths, base codes, register indexes and the sequence state record.
// ----------------------------------------------------------------------------
package dwcc_pkg;

	localparam int WINDOW_MAX = 1024;
	localparam int ADDR_W     = $clog2(WINDOW_MAX);
	localparam int LEN_W      = 11;
	localparam int CODE_W     = 3;
	localparam int NUM_BASES  = 4;
	localparam int MATCH_W    = 32;
	localparam int SYM_W      = 8;
	localparam int CFG_IDX_W  = 3;

	localparam logic [SYM_W-1:0] ASCII_A = 8'h41;
	localparam logic [SYM_W-1:0] ASCII_C = 8'h43;
	localparam logic [SYM_W-1:0] ASCII_G = 8'h47;
	localparam logic [SYM_W-1:0] ASCII_T = 8'h54;

	typedef enum logic [CODE_W-1:0] {
		CODE_OTHER = 3'd0,
		CODE_A     = 3'd1,
		CODE_C     = 3'd2,
		CODE_G     = 3'd3,
		CODE_T     = 3'd4
	} base_code_t;

	// base code of each counter slot, A first
	localparam base_code_t BASE_OF [NUM_BASES] = '{CODE_A, CODE_C, CODE_G, CODE_T};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 3'd0,
		REG_MIN_A         = 3'd1,
		REG_MIN_C         = 3'd2,
		REG_MIN_G         = 3'd3,
		REG_MIN_T         = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]                   wp;
		logic [LEN_W-1:0]                    fill;
		logic [NUM_BASES-1:0][LEN_W-1:0]     counts;
		logic [MATCH_W-1:0]                  total;
	} seq_state_t;

	typedef struct packed {
		logic [LEN_W-1:0]                    len;
		logic [NUM_BASES-1:0][LEN_W-1:0]     min_cnt;
	} win_cfg_t;

	function automatic base_code_t base_code(input logic [SYM_W-1:0] sym);
		base_code_t c;
		case (sym)
			ASCII_A: c = CODE_A;
			ASCII_C: c = CODE_C;
			ASCII_G: c = CODE_G;
			ASCII_T: c = CODE_T;
			default: c = CODE_OTHER;
		endcase
		return c;
	endfunction

	// clamp a written length into 1..WINDOW_MAX
	function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] raw);
		logic [LEN_W-1:0] l;
		if (raw == '0) begin
			l = LEN_W'(1);
		end else if (raw > LEN_W'(WINDOW_MAX)) begin
			l = LEN_W'(WINDOW_MAX);
		end else begin
			l = raw;
		end
		return l;
	endfunction

endpackage

FILE: rtl/dwcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA window composition check - symbol ring memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dwcc_ram (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [dwcc_pkg::ADDR_W-1:0]    wr_addr,
	input  logic [dwcc_pkg::CODE_W-1:0]    wr_data,
	input  logic [dwcc_pkg::ADDR_W-1:0]    rd_addr,
	output logic [dwcc_pkg::CODE_W-1:0]    rd_data
);
	import dwcc_pkg::*;

	logic [CODE_W-1:0] mem [WINDOW_MAX];
	logic [CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/dwcc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA window composition check - window update
// Next sequence state, full and match flags for one symbol.
// ----------------------------------------------------------------------------
module dwcc_update (
	input  dwcc_pkg::seq_state_t   cur,
	input  dwcc_pkg::win_cfg_t     cfg,
	input  dwcc_pkg::base_code_t   code,
	input  logic                   restart,
	input  dwcc_pkg::base_code_t   old_code,
	output dwcc_pkg::seq_state_t   nxt,
	output logic                   full,
	output logic                   match
);
	import dwcc_pkg::*;

	seq_state_t base;
	logic       evict;
	logic       mins_ok;

	always_comb begin
		base = cur;
		if (restart) begin
			base = '0;
		end
		evict = (base.fill >= cfg.len);
		nxt = base;
		nxt.wp = base.wp + ADDR_W'(1);
		if (!evict) begin
			nxt.fill = base.fill + LEN_W'(1);
		end
		mins_ok = 1'b1;
		for (int b = 0; b < NUM_BASES; b++) begin
			// drop the symbol leaving the window, add the one entering
			if (evict && (old_code == BASE_OF[b]) && (base.counts[b] != '0)) begin
				nxt.counts[b] = nxt.counts[b] - LEN_W'(1);
			end
			if (code == BASE_OF[b]) begin
				nxt.counts[b] = nxt.counts[b] + LEN_W'(1);
			end
			mins_ok = mins_ok & (nxt.counts[b] >= cfg.min_cnt[b]);
		end
		full  = (nxt.fill >= cfg.len);
		match = full & mins_ok;
		if (match && (base.total != '1)) begin
			nxt.total = base.total + MATCH_W'(1);
		end
	end

endmodule

FILE: rtl/dna_window_composition_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA window composition check - top level
// Sliding-window A/C/G/T composition filter over a nucleotide byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request carries a symbol byte and
//   a restart flag; restart clears the window, base counts and match total
//   before the symbol is taken in.
//   Output channel (out_valid/out_ready): one result per symbol, in order:
//   window_full, window_match and the saturating match_total.
//   Config channel (cfg_valid/cfg_ready): always ready; index 0 is the window
//   length (clamped to 1..1024, and writing it clears the sequence), 1..4 are
//   the minimum A, C, G and T counts. Write only while the block is idle.
// Timing:
//   An accepted request passes the input register, then the result register.
//   Throughput is one symbol per cycle while the result channel is not
//   stalled, set by the single update stage and the registered read of the
//   ring memory, which is addressed from the next pointer.
// Reset:
//   Clears pointer, fill count, base counts and match total, sets window
//   length 1 and all minimums 0. The ring memory is not cleared.
// Stall:
//   When out_ready is low the result is held, the update stage holds its
//   request and in_ready drops only once both are occupied.
// ----------------------------------------------------------------------------
module dna_window_composition_check (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dwcc_pkg::SYM_W-1:0]         symbol,
	input  logic                               restart,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               window_full,
	output logic                               window_match,
	output logic [dwcc_pkg::MATCH_W-1:0]       match_total,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dwcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dwcc_pkg::LEN_W-1:0]         cfg_data
);
	import dwcc_pkg::*;

	// configuration and sequence state
	win_cfg_t       cfg_q;
	seq_state_t     state_q;
	seq_state_t     state_nxt;
	seq_state_t     upd_state;
	logic           len_wr;

	// update stage
	logic           valid_s1;
	base_code_t     code_s1;
	logic           restart_s1;
	logic           fire_s1;

	// result register
	logic                 out_valid_q;
	logic                 full_q;
	logic                 match_q;
	logic [MATCH_W-1:0]   total_q;
	logic                 upd_full;
	logic                 upd_match;

	// ring memory and same-slot bypass
	logic [ADDR_W-1:0]    rd_addr;
	logic [CODE_W-1:0]    ram_rd_data;
	logic                 byp_q;
	base_code_t           byp_code_q;
	base_code_t           old_code;

	assign cfg_ready = 1'b1;
	assign len_wr    = cfg_valid && (cfg_index == REG_WINDOW_LENGTH);

	// advance the stage when the result register is free or being drained
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.len     <= LEN_W'(1);
			cfg_q.min_cnt <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LENGTH: cfg_q.len        <= eff_length(cfg_data);
				REG_MIN_A:         cfg_q.min_cnt[0] <= cfg_data;
				REG_MIN_C:         cfg_q.min_cnt[1] <= cfg_data;
				REG_MIN_G:         cfg_q.min_cnt[2] <= cfg_data;
				REG_MIN_T:         cfg_q.min_cnt[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: hold the request's base code and restart flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1    <= base_code(symbol);
			restart_s1 <= restart;
		end
	end

	// the symbol leaving the window; when the window is one long it is the
	// one written in the previous cycle, so take it from the bypass
	assign old_code = byp_q ? byp_code_q : base_code_t'(ram_rd_data);

	dwcc_update u_update (
		.cur      (state_q),
		.cfg      (cfg_q),
		.code     (code_s1),
		.restart  (restart_s1),
		.old_code (old_code),
		.nxt      (upd_state),
		.full     (upd_full),
		.match    (upd_match)
	);

	// next sequence state: a length write clears it, a fired stage advances it
	always_comb begin
		state_nxt = state_q;
		if (len_wr) begin
			state_nxt = '0;
		end else if (fire_s1) begin
			state_nxt = upd_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_nxt;
		end
	end

	// read the slot that the next symbol will evict, from the next pointer
	assign rd_addr = ADDR_W'({1'b0, state_nxt.wp} - cfg_q.len);

	dwcc_ram u_ram (
		.clk     (clk),
		.wr_en   (fire_s1),
		.wr_addr (state_q.wp & {ADDR_W{!restart_s1}}),
		.wr_data (code_s1),
		.rd_addr (rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= fire_s1 && (cfg_q.len == LEN_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		byp_code_q <= code_s1;
	end

	// result register: hold until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			full_q  <= upd_full;
			match_q <= upd_match;
			total_q <= upd_state.total;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_full  = full_q;
	assign window_match = match_q;
	assign match_total  = total_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_fill_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fill <= cfg_q.len)
		else $error("fill count exceeds window length");

	a_counts_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		({2'b00, state_q.counts[0]} + {2'b00, state_q.counts[1]}
		 + {2'b00, state_q.counts[2]} + {2'b00, state_q.counts[3]})
		<= {2'b00, state_q.fill})
		else $error("base counts exceed window fill");

	a_match_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && match_q |-> full_q)
		else $error("match reported on a window that is not full");

	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !restart_s1 && !len_wr |=>
		(state_q.total == $past(state_q.total))
		|| (state_q.total == $past(state_q.total) + MATCH_W'(1)))
		else $error("match total moved by more than one");

endmodule

FILE: bench/dna_window_composition_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA window composition check - testbench
// Streams nucleotide bytes through the block under random back-pressure and
// scores every symbol against a window composition model kept here. Results
// are compared field by field, in order, with the model's verdicts.
// ----------------------------------------------------------------------------
module dna_window_composition_check_tb;
	import dwcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int REPORT_CAP     = 100;
	localparam int SMALL_PHASES   = 6;
	localparam int SMALL_ITEMS    = 14;
	localparam int LONG_ITEMS     = 1040;

	// window lengths of the short phases; the longest one never fills
	localparam int SMALL_SPANS [SMALL_PHASES] = '{1, 2, 5, 12, 40, 1024};
	// sender idle and receiver stall, in percent, taken in turn per phase
	localparam int SEND_IDLE [4] = '{0, 50, 0, 35};
	localparam int STALL_IDLE [4] = '{0, 0, 50, 35};

	localparam logic [SYM_W-1:0] LETTERS [NUM_BASES] = '{ASCII_A, ASCII_C, ASCII_G, ASCII_T};
	localparam logic [SYM_W-1:0] ASCII_N       = "N";
	localparam logic [SYM_W-1:0] ASCII_LOWER_A = "a";
	localparam logic [SYM_W-1:0] SYM_ZEROS     = '0;
	localparam logic [SYM_W-1:0] SYM_ONES      = '1;
	localparam logic [SYM_W-1:0] SYM_HIGH_BIT  = 8'h80;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             rst;
	} request_t;

	typedef struct packed {
		logic               full;
		logic               hit;
		logic [MATCH_W-1:0] total;
	} verdict_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [SYM_W-1:0]     symbol    = '0;
	logic                 restart   = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 window_full;
	logic                 window_match;
	logic [MATCH_W-1:0]   match_total;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data  = '0;

	request_t pending_symbols [$];
	verdict_t window_verdicts [$];
	int       send_idle_pct = 0;
	int       stall_pct     = 0;
	int       fault_count   = 0;
	int       idle_cycles   = 0;

	// composition model: ring of base codes, window fill and per-base tallies
	base_code_t         ring [WINDOW_MAX];
	logic [ADDR_W-1:0]  head;
	int unsigned        filled;
	int unsigned        base_tally [NUM_BASES];
	logic [MATCH_W-1:0] running_total;
	logic [LEN_W-1:0]   len_setting;
	logic [LEN_W-1:0]   min_setting [NUM_BASES];

	dna_window_composition_check uut (.*);

	always #6 clk = ~clk;

	// counter slot of a base letter, -1 for any other byte
	function automatic int base_slot(input logic [SYM_W-1:0] sym);
		int slot;
		slot = -1;
		for (int b = 0; b < NUM_BASES; b++) begin
			if (sym == LETTERS[b]) slot = b;
		end
		return slot;
	endfunction

	// clamp the written length into the ring's range
	function automatic int unsigned window_span();
		if (len_setting == '0) return 1;
		if (int'(len_setting) > WINDOW_MAX) return WINDOW_MAX;
		return 32'(len_setting);
	endfunction

	function automatic void restart_sequence();
		head = '0;
		filled = 0;
		foreach (base_tally[b]) base_tally[b] = 0;
		running_total = '0;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [LEN_W-1:0] data);
		// a new length starts a fresh sequence; indexes past the list are dropped
		if (idx == REG_WINDOW_LENGTH) begin
			len_setting = data;
			restart_sequence();
		end else if (idx >= REG_MIN_A && idx <= REG_MIN_T) begin
			min_setting[idx - REG_MIN_A] = data;
		end
	endfunction

	// take one symbol into the window and return the verdict it produces
	function automatic verdict_t score_symbol(input request_t rq);
		int unsigned span;
		int          slot;
		int          old_slot;
		base_code_t  oldest;
		verdict_t    v;
		span = window_span();
		slot = base_slot(rq.sym);
		if (rq.rst) restart_sequence();
		if (filled >= span) begin
			// drop the symbol that slides out of the window
			oldest = ring[(int'(head) + WINDOW_MAX - int'(span)) % WINDOW_MAX];
			if (oldest != CODE_OTHER) begin
				old_slot = int'(oldest) - int'(CODE_A);
				if (base_tally[old_slot] > 0) base_tally[old_slot]--;
			end
		end else begin
			filled++;
		end
		ring[head] = (slot < 0) ? CODE_OTHER : BASE_OF[slot];
		head = head + ADDR_W'(1);
		if (slot >= 0) base_tally[slot]++;
		v.full = (filled >= span);
		v.hit = v.full;
		for (int b = 0; b < NUM_BASES; b++) begin
			if (base_tally[b] < 32'(min_setting[b])) v.hit = 1'b0;
		end
		// hold the total once it reaches the top
		if (v.hit && running_total != '1) running_total = running_total + MATCH_W'(1);
		v.total = running_total;
		return v;
	endfunction

	task automatic report_mismatch(input string field, input logic [MATCH_W-1:0] got,
			input logic [MATCH_W-1:0] want);
		// keep the log readable when a fault repeats on every symbol
		if (fault_count < REPORT_CAP)
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
		fault_count++;
	endtask

	// call at a rising edge; leaves the write valid high for the next write
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [LEN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
	endtask

	task automatic configure(input int unsigned span_raw, input int unsigned floor_a,
			input int unsigned floor_c, input int unsigned floor_g, input int unsigned floor_t);
		write_register(REG_WINDOW_LENGTH, LEN_W'(span_raw));
		write_register(REG_MIN_A, LEN_W'(floor_a));
		write_register(REG_MIN_C, LEN_W'(floor_c));
		write_register(REG_MIN_G, LEN_W'(floor_g));
		write_register(REG_MIN_T, LEN_W'(floor_t));
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_symbol(input logic [SYM_W-1:0] sym, input logic rst);
		request_t rq;
		rq.sym = sym;
		rq.rst = rst;
		pending_symbols.push_back(rq);
	endtask

	// mostly clean A/C/G/T runs, with a sprinkling of arbitrary bytes
	task automatic queue_random(input int count, input int restart_pct);
		request_t rq;
		repeat (count) begin
			if ($urandom_range(99) < 85) rq.sym = LETTERS[$urandom_range(NUM_BASES - 1)];
			else rq.sym = SYM_W'($urandom_range(255));
			rq.rst = ($urandom_range(99) < restart_pct);
			pending_symbols.push_back(rq);
		end
	endtask

	// wait for the queue to empty and every verdict to come back, then settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_symbols.size() != 0 || in_valid || window_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request driver: score each accepted symbol, then offer the next one.
	// Valid only drops once the current request has gone through.
	always @(posedge clk) begin : feed_symbols
		request_t taken;
		request_t offer;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken.sym = symbol;
				taken.rst = restart;
				window_verdicts.push_back(score_symbol(taken));
			end
			if (!in_valid || in_ready) begin
				if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offer = pending_symbols.pop_front();
					in_valid <= 1'b1;
					symbol   <= offer.sym;
					restart  <= offer.rst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest verdict,
	// and stall the result channel at the phase's rate.
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (window_verdicts.size() == 0) begin
					report_mismatch("unexpected result", match_total, '0);
				end else begin
					want = window_verdicts.pop_front();
					if (window_full !== want.full)
						report_mismatch("window_full", MATCH_W'(window_full),
							MATCH_W'(want.full));
					if (window_match !== want.hit)
						report_mismatch("window_match", MATCH_W'(window_match),
							MATCH_W'(want.hit));
					if (match_total !== want.total)
						report_mismatch("match_total", match_total, want.total);
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: end the run once nothing has moved on any channel for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** dna_window_composition_check: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int unsigned span;
		int unsigned quarter;
		// model starts from the reset settings: length one, no minimums
		foreach (ring[i]) ring[i] = CODE_OTHER;
		len_setting = LEN_W'(1);
		foreach (min_setting[b]) min_setting[b] = '0;
		restart_sequence();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: every symbol fills the window and matches; a restart
		// on the all-ones byte drops the total back to one.
		queue_symbol(ASCII_A, 1'b0);
		queue_symbol(ASCII_C, 1'b0);
		queue_symbol(ASCII_G, 1'b0);
		queue_symbol(ASCII_T, 1'b0);
		queue_symbol(SYM_ZEROS, 1'b0);
		queue_symbol(SYM_ONES, 1'b1);
		queue_symbol(ASCII_LOWER_A, 1'b0);
		wait_drained();

		// Writes past the last register must leave everything alone.
		for (int r = REG_MIN_T + 1; r < (1 << CFG_IDX_W); r++)
			write_register(CFG_IDX_W'(r), '1);
		// Window of four needing one of each base: match, slide, lose a base to
		// an unknown byte, then restart mid-stream and refill.
		configure(4, 1, 1, 1, 1);
		@(negedge clk);
		queue_symbol(ASCII_A, 1'b0);
		queue_symbol(ASCII_C, 1'b0);
		queue_symbol(ASCII_G, 1'b0);
		queue_symbol(ASCII_T, 1'b0);
		queue_symbol(ASCII_A, 1'b0);
		queue_symbol(ASCII_N, 1'b0);
		queue_symbol(ASCII_G, 1'b1);
		queue_symbol(ASCII_C, 1'b0);
		queue_symbol(ASCII_A, 1'b0);
		queue_symbol(ASCII_T, 1'b0);
		wait_drained();

		// Minimum beyond the window: full but never a match.
		configure(2, (1 << LEN_W) - 1, 0, 0, 0);
		@(negedge clk);
		repeat (3) queue_symbol(ASCII_A, 1'b0);
		wait_drained();

		// Length zero behaves as length one.
		configure(0, 0, 0, 0, 0);
		@(negedge clk);
		queue_symbol(ASCII_G, 1'b0);
		queue_symbol(SYM_HIGH_BIT, 1'b0);
		wait_drained();

		// Short windows under each idling pattern, with occasional restarts.
		for (int p = 0; p < SMALL_PHASES; p++) begin
			span = SMALL_SPANS[p];
			quarter = span / 4;
			if (span >= WINDOW_MAX)
				configure(span, span, span, span, span);
			else
				configure(span, $urandom_range(quarter), $urandom_range(quarter),
					$urandom_range(quarter), $urandom_range(quarter));
			@(negedge clk);
			send_idle_pct = SEND_IDLE[p % 4];
			stall_pct     = STALL_IDLE[p % 4];
			queue_random(SMALL_ITEMS / 2, 4);
			// hold the sender until every outstanding result is back
			wait_drained();
			@(negedge clk);
			queue_random(SMALL_ITEMS - SMALL_ITEMS / 2, 4);
			wait_drained();
		end

		// Largest window, written with an over-range length: fill the whole ring
		// and slide past it with minimums near the expected base share.
		configure((1 << LEN_W) - 1, 170 + $urandom_range(30), 170 + $urandom_range(30),
			170 + $urandom_range(30), 170 + $urandom_range(30));
		@(negedge clk);
		send_idle_pct = SEND_IDLE[3];
		stall_pct     = STALL_IDLE[3];
		queue_random(LONG_ITEMS, 0);
		wait_drained();

		if (fault_count == 0)
			$display("** dna_window_composition_check: PASSED **");
		else
			$display("** dna_window_composition_check: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/dwcc_pkg.sv
rtl/dwcc_ram.sv
rtl/dwcc_update.sv
rtl/dna_window_composition_check.sv
bench/dna_window_composition_check_tb.sv
